// ===== design/bsm_pkg.sv =====
package bsm_pkg;

    // Instruction codes.
    localparam logic [4:0] OP_POP     = 5'd0;
    localparam logic [4:0] OP_PUSH8   = 5'd1;
    localparam logic [4:0] OP_PUSH16  = 5'd2;
    localparam logic [4:0] OP_PUSH32  = 5'd3;
    localparam logic [4:0] OP_SADD    = 5'd4;
    localparam logic [4:0] OP_SMOD    = 5'd8;
    localparam logic [4:0] OP_UADD    = 5'd9;
    localparam logic [4:0] OP_UMOD    = 5'd13;
    localparam logic [4:0] OP_END     = 5'd14;
    localparam logic [4:0] OP_CALL    = 5'd15;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FINISHED  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_UNDEF_FN  = 3'd5;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STACK_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_BUILTIN_COUNT = 2'd1;
    localparam logic [1:0] CFG_BUILTIN_MASK  = 2'd2;
    localparam logic [1:0] CFG_START_ADDRESS = 2'd3;

    // Arithmetic kinds.
    localparam logic [2:0] K_ADD = 3'd0;
    localparam logic [2:0] K_SUB = 3'd1;
    localparam logic [2:0] K_MUL = 3'd2;
    localparam logic [2:0] K_DIV = 3'd3;
    localparam logic [2:0] K_MOD = 3'd4;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [31:0] immediate;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        builtin_request;
        logic [15:0] builtin_id;
        logic [7:0]  arith_value;
        logic [15:0] next_address;
        logic [8:0]  stack_depth;
    } t_out_item;

    typedef struct packed {
        logic [2:0] kind;
        logic       sgn;
    } t_alu_req;

endpackage

// ===== design/byte_stack_machine_step.sv =====
// Channel  Direction  Handshake                     Payload
// in       input      i_in_valid / o_in_stall       i_in_item (t_in_item)
// out      output     o_out_valid / i_out_stall     o_out_item (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item at a time: pop, end, invalid codes and any step that fails at decode go
// straight to the output; a push writes one byte per cycle, since the stack memory has one byte port.
// Add, subtract and multiply use two registered stack reads; a call or a divide by zero
// reads both operands and ends without the ALU; divide and modulo use the one-bit-per-cycle divider.
// Reset clears head, instruction address, configuration registers and output valid; stack bytes are not cleared.
// A stalled result sits in the output register while the next item is taken.
module byte_stack_machine_step import bsm_pkg::*; #(
    parameter int STACK_BYTES   = 256,
    parameter int BUILTIN_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int AW = $clog2(STACK_BYTES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_EXEC = 8'b00000010,
        S_PUSH = 8'b00000100,
        S_RDA  = 8'b00001000,
        S_RDB  = 8'b00010000,
        S_CALC = 8'b00100000,
        S_WRES = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    t_state      r_state;
    logic [4:0]  r_op;
    logic [31:0] r_imm;
    logic [8:0]  r_head;
    logic [15:0] r_addr;
    logic [2:0]  r_status;
    logic        r_req;
    logic [15:0] r_id;
    logic [7:0]  r_aval, r_a, r_b;
    logic [1:0]  r_cnt;
    logic [8:0]  r_limit;
    logic [6:0]  r_bcount;
    logic [63:0] r_mask;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_accept, w_we, w_sgn, w_alu_start, w_alu_done, w_out_free;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]  w_wdata, w_rdata, w_alu_res;
    logic [16:0] w_eff;
    logic [6:0]  w_bcnt;
    logic [2:0]  w_nbytes;
    logic [15:0] w_id;
    t_alu_req    w_alu_req;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Limits clamped to the built sizes.
    assign w_eff  = ({8'd0, r_limit} > 17'(STACK_BYTES)) ? 17'(STACK_BYTES) : {8'd0, r_limit};
    assign w_bcnt = (r_bcount > 7'(BUILTIN_SLOTS)) ? 7'(BUILTIN_SLOTS) : r_bcount;

    // Decode of push length and arithmetic kind.
    assign w_nbytes = (r_op == OP_PUSH8) ? 3'd1 : (r_op == OP_PUSH16) ? 3'd2 : 3'd4;
    assign w_sgn    = (r_op <= OP_SMOD);
    assign w_alu_req.sgn  = w_sgn;
    assign w_alu_req.kind = w_sgn ? 3'(r_op - OP_SADD) : 3'(r_op - OP_UADD);
    assign w_id     = {r_a, r_b};

    // Stack memory port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_head + {7'd0, r_cnt});
        w_wdata = r_imm[8*r_cnt +: 8];
        w_raddr = AW'(r_head - 9'd1);
        if (r_state == S_PUSH) begin
            w_we = 1'b1;
        end else if (r_state == S_WRES) begin
            w_waddr = AW'(r_head);
            w_wdata = w_alu_res;
            w_we    = w_alu_done && ({8'd0, r_head} + 17'd1 < w_eff);
        end
        if (r_state == S_RDA) begin
            w_raddr = AW'(r_head - 9'd2);
        end
    end

    assign w_alu_start = (r_state == S_CALC) && (r_op != OP_CALL)
        && !(((w_alu_req.kind == K_DIV) || (w_alu_req.kind == K_MOD)) && r_b == 8'd0);

    bsm_stack_ram #(.AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    bsm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_alu_start),
        .i_req   (w_alu_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (w_alu_done),
        .o_result(w_alu_res)
    );

    // Instruction sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= 9'd0;
            r_addr      <= 16'd0;
            r_limit     <= 9'd256;
            r_bcount    <= 7'd0;
            r_mask      <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STACK_LIMIT:   r_limit  <= i_cfg_data[8:0];
                    CFG_BUILTIN_COUNT: r_bcount <= i_cfg_data[6:0];
                    CFG_BUILTIN_MASK:  r_mask   <= i_cfg_data;
                    CFG_START_ADDRESS: r_addr   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_in_item.opcode;
                        r_imm    <= i_in_item.immediate;
                        r_status <= ST_OK;
                        r_req    <= 1'b0;
                        r_id     <= 16'd0;
                        r_aval   <= 8'd0;
                        r_cnt    <= 2'd0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    if (r_op == OP_POP) begin
                        r_addr <= r_addr + 16'd2;
                        if (r_head < {1'b0, r_imm[7:0]}) begin
                            r_status <= ST_UNDERFLOW;
                        end else begin
                            r_head <= r_head - {1'b0, r_imm[7:0]};
                        end
                    end else if (r_op == OP_PUSH8 || r_op == OP_PUSH16 || r_op == OP_PUSH32) begin
                        r_addr <= r_addr + 16'(w_nbytes) + 16'd1;
                        if ({8'd0, r_head} + 17'(w_nbytes) >= w_eff) begin
                            r_status <= ST_OVERFLOW;
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end else if (r_op >= OP_SADD && r_op <= OP_UMOD) begin
                        r_addr <= r_addr + 16'd1;
                        if (r_head < 9'd2) begin
                            // A lone byte is still popped before the failure.
                            r_status <= ST_UNDERFLOW;
                            r_head   <= 9'd0;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end else if (r_op == OP_END) begin
                        r_addr   <= 16'd0;
                        r_status <= ST_FINISHED;
                    end else if (r_op == OP_CALL) begin
                        r_addr <= r_addr + 16'd1;
                        if (r_head < 9'd2) begin
                            r_status <= ST_UNDERFLOW;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end else begin
                        r_status <= ST_INVALID;
                    end
                end
                S_PUSH: begin
                    r_cnt <= r_cnt + 2'd1;
                    if ({1'b0, r_cnt} == w_nbytes - 3'd1) begin
                        r_head  <= r_head + 9'(w_nbytes);
                        r_state <= S_DONE;
                    end
                end
                S_RDA: begin
                    r_a     <= w_rdata;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_b     <= w_rdata;
                    r_head  <= r_head - 9'd2;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (r_op == OP_CALL) begin
                        r_id    <= w_id;
                        r_state <= S_DONE;
                        if (w_id >= {9'd0, w_bcnt} || !r_mask[w_id[5:0]]) begin
                            r_status <= ST_UNDEF_FN;
                        end else begin
                            r_req <= 1'b1;
                        end
                    end else if (w_alu_start) begin
                        r_state <= S_WRES;
                    end else begin
                        r_status <= ST_DIV_ZERO;
                        r_state  <= S_DONE;
                    end
                end
                S_WRES: begin
                    if (w_alu_done) begin
                        r_state <= S_DONE;
                        if (w_we) begin
                            r_head <= r_head + 9'd1;
                            r_aval <= w_alu_res;
                        end else begin
                            r_status <= ST_OVERFLOW;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.status          <= r_status;
                        r_out.builtin_request <= r_req;
                        r_out.builtin_id      <= r_id;
                        r_out.arith_value     <= r_aval;
                        r_out.next_address    <= r_addr;
                        r_out.stack_depth     <= r_head;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/bsm_stack_ram.sv =====
module bsm_stack_ram #(
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    // Byte-wide stack store with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bsm_alu.sv =====
module bsm_alu import bsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_alu_req  i_req,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic      o_done,
    output logic [7:0] o_result
);

    logic       r_busy, r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_quo, r_rem, r_div, r_res;
    logic       r_qneg, r_rneg, r_mod;
    logic [7:0] w_amag, w_bmag;
    logic [8:0] w_trial;
    logic       w_ge;
    logic [7:0] w_rem_nx, w_quo_nx;

    // Magnitudes of the operands for the signed divide.
    assign w_amag = (i_req.sgn && i_a[7]) ? 8'(-i_a) : i_a;
    assign w_bmag = (i_req.sgn && i_b[7]) ? 8'(-i_b) : i_b;

    // One restoring divide step per cycle.
    assign w_trial  = {r_rem, r_quo[7]};
    assign w_ge     = w_trial >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? 8'(w_trial - {1'b0, r_div}) : w_trial[7:0];
    assign w_quo_nx = {r_quo[6:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_qneg <= i_req.sgn && (i_a[7] ^ i_b[7]);
                r_rneg <= i_req.sgn && i_a[7];
                r_mod  <= (i_req.kind == K_MOD);
                case (i_req.kind)
                    K_ADD: begin
                        r_res  <= i_a + i_b;
                        r_done <= 1'b1;
                    end
                    K_SUB: begin
                        r_res  <= i_a - i_b;
                        r_done <= 1'b1;
                    end
                    K_MUL: begin
                        r_res  <= 8'(i_a * i_b);
                        r_done <= 1'b1;
                    end
                    default: begin
                        r_busy <= 1'b1;
                        r_cnt  <= 3'd0;
                        r_quo  <= w_amag;
                        r_rem  <= 8'd0;
                        r_div  <= w_bmag;
                    end
                endcase
            end else if (r_busy) begin
                r_quo <= w_quo_nx;
                r_rem <= w_rem_nx;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    // Last step: apply the signs of the truncating divide.
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_mod) begin
                        r_res <= r_rneg ? 8'(-w_rem_nx) : w_rem_nx;
                    end else begin
                        r_res <= r_qneg ? 8'(-w_quo_nx) : w_quo_nx;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== design/bsm_checker.sv =====
module bsm_checker import bsm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A builtin request comes only with an ok status.
    a_req_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.builtin_request |-> o_out_item.status == ST_OK)
        else $error("builtin request with failure status");

    // A failed step pushes no arithmetic value.
    a_aval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.arith_value == 8'd0)
        else $error("arith value on failed step");

    // The stack head stays below the largest limit.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.stack_depth < 9'd256)
        else $error("stack depth out of range");

    // An item taken blocks the input until its work is done.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after accept");

endmodule

bind byte_stack_machine_step bsm_checker u_bsm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

// ===== verif/byte_stack_machine_step_tb.sv =====
`timescale 1ns / 1ps

module byte_stack_machine_step_tb;
    import bsm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    byte_stack_machine_step i_dut (.*);

    // Predicted machine state and register copies.
    logic [7:0]  stk_bytes [256];
    int unsigned stk_head;
    logic [15:0] instr_addr;
    int unsigned stack_limit_reg;
    int unsigned builtin_count_reg;
    logic [63:0] builtin_mask_reg;

    t_out_item   pending_results [$];
    bit          failed = 1'b0;
    bit          no_idle = 1'b0;
    int          quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Push n bytes, least significant first, if the limit allows it.
    function automatic bit model_push(logic [31:0] value, int unsigned n);
        int unsigned lim;
        lim = (stack_limit_reg > 256) ? 256 : stack_limit_reg;
        if (stk_head + n >= lim) return 1'b0;
        for (int unsigned i = 0; i < n; i++) stk_bytes[(stk_head + i) % 256] = value[8*i +: 8];
        stk_head += n;
        return 1'b1;
    endfunction

    // Work out the result of one instruction and advance the predicted state.
    function automatic t_out_item predict_step(logic [4:0] op, logic [31:0] imm);
        t_out_item   res;
        int unsigned n, kind, cnt, id;
        int          x, y, z;
        logic [7:0]  a, b, r;
        bit          sgn;
        res = '0;
        res.status = ST_OK;
        if (op == OP_POP) begin
            instr_addr += 2;
            if (stk_head < imm[7:0]) res.status = ST_UNDERFLOW;
            else stk_head -= imm[7:0];
        end else if (op >= OP_PUSH8 && op <= OP_PUSH32) begin
            n = (op == OP_PUSH8) ? 1 : (op == OP_PUSH16) ? 2 : 4;
            instr_addr += 16'(n + 1);
            if (!model_push(imm, n)) res.status = ST_OVERFLOW;
        end else if (op >= OP_SADD && op <= OP_UMOD) begin
            sgn = (op <= OP_SMOD);
            kind = sgn ? op - OP_SADD : op - OP_UADD;
            instr_addr += 1;
            if (stk_head < 2) begin
                // A lone byte is consumed even though the operation fails.
                stk_head = 0;
                res.status = ST_UNDERFLOW;
            end else begin
                a = stk_bytes[stk_head - 1];
                b = stk_bytes[stk_head - 2];
                stk_head -= 2;
                if ((kind == K_DIV || kind == K_MOD) && b == 0) begin
                    res.status = ST_DIV_ZERO;
                end else begin
                    x = sgn ? int'($signed(a)) : int'(a);
                    y = sgn ? int'($signed(b)) : int'(b);
                    case (kind)
                        K_ADD: z = x + y;
                        K_SUB: z = x - y;
                        K_MUL: z = x * y;
                        K_DIV: z = x / y;
                        default: z = x % y;
                    endcase
                    r = z[7:0];
                    if (model_push({24'd0, r}, 1)) res.arith_value = r;
                    else res.status = ST_OVERFLOW;
                end
            end
        end else if (op == OP_END) begin
            instr_addr = 0;
            res.status = ST_FINISHED;
        end else if (op == OP_CALL) begin
            instr_addr += 1;
            if (stk_head < 2) begin
                res.status = ST_UNDERFLOW;
            end else begin
                cnt = (builtin_count_reg > 64) ? 64 : builtin_count_reg;
                stk_head -= 2;
                id = {stk_bytes[stk_head + 1], stk_bytes[stk_head]};
                res.builtin_id = id[15:0];
                if (id >= cnt || !builtin_mask_reg[id % 64]) res.status = ST_UNDEF_FN;
                else res.builtin_request = 1'b1;
            end
        end else begin
            res.status = ST_INVALID;
        end
        res.next_address = instr_addr;
        res.stack_depth = stk_head[8:0];
        return res;
    endfunction

    // Send one item, with a random idle gap first, and record what it should give.
    task automatic send_item(logic [4:0] op, logic [31:0] imm);
        while (!no_idle && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{opcode: op, immediate: imm};
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_step(op, imm));
    endtask

    // Lower valid and hold off until every expected item has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write one register; the block is idle whenever this is called.
    task automatic write_reg(logic [1:0] index, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_STACK_LIMIT: stack_limit_reg = data[8:0];
            CFG_BUILTIN_COUNT: builtin_count_reg = data[6:0];
            CFG_BUILTIN_MASK: builtin_mask_reg = data;
            default: begin
                instr_addr = data[15:0];
            end
        endcase
    endtask

    task automatic arith_pair(logic [4:0] op, logic [7:0] top, logic [7:0] second);
        send_item(OP_PUSH8, {24'd0, second});
        send_item(OP_PUSH8, {24'd0, top});
        send_item(op, $urandom);
    endtask

    // Directed cases: field extremes, every instruction and the corner cases.
    task automatic test_directed();
        write_reg(CFG_BUILTIN_COUNT, 64'd3);
        write_reg(CFG_BUILTIN_MASK, 64'h5);
        send_item(OP_SADD, 32'd0);
        send_item(OP_PUSH8, 32'hFFFF_FFA5);
        send_item(OP_UADD, 32'd0);
        send_item(OP_PUSH32, 32'hFFFF_FFFF);
        send_item(OP_PUSH32, 32'h0000_0000);
        send_item(OP_PUSH16, 32'h1234_8001);
        send_item(OP_POP, 32'hFFFF_FF00 | 32'd255);
        send_item(OP_POP, 32'd10);
        arith_pair(OP_SADD + K_DIV, 8'h80, 8'hFF);
        arith_pair(OP_SADD + K_MOD, 8'h80, 8'hFF);
        arith_pair(OP_UADD + K_DIV, 8'h37, 8'h00);
        for (int k = K_ADD; k <= K_MOD; k++) begin
            arith_pair(OP_SADD + k[4:0], 8'h9C, 8'h07);
            arith_pair(OP_UADD + k[4:0], 8'hFE, 8'h81);
        end
        send_item(OP_POP, 32'd255);
        send_item(OP_CALL, 32'd0);
        send_item(OP_PUSH16, 32'd2);
        send_item(OP_CALL, 32'd0);
        send_item(OP_PUSH16, 32'd1);
        send_item(OP_CALL, 32'd0);
        send_item(OP_PUSH16, 32'hFFFF);
        send_item(OP_CALL, 32'd0);
        send_item(5'd16, 32'd0);
        send_item(5'd31, 32'hFFFF_FFFF);
        send_item(OP_END, 32'd0);
        drain_results();
    endtask

    // Register extremes: empty and clamped limits, address wrap, all slots defined.
    task automatic test_register_extremes();
        write_reg(CFG_STACK_LIMIT, 64'd0);
        write_reg(CFG_START_ADDRESS, 64'hFFFF);
        send_item(OP_PUSH8, 32'h11);
        send_item(OP_PUSH32, 32'h11);
        drain_results();
        write_reg(CFG_STACK_LIMIT, 64'd4);
        send_item(OP_PUSH16, 32'h0203);
        send_item(OP_PUSH8, 32'h44);
        send_item(OP_PUSH8, 32'h55);
        send_item(OP_UADD, 32'd0);
        send_item(OP_POP, 32'd3);
        drain_results();
        write_reg(CFG_STACK_LIMIT, 64'h1FF);
        write_reg(CFG_BUILTIN_COUNT, 64'h7F);
        write_reg(CFG_BUILTIN_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_START_ADDRESS, 64'd0);
        for (int i = 0; i < 70; i++) send_item(OP_PUSH32, $urandom);
        send_item(OP_PUSH16, 32'd63);
        send_item(OP_CALL, 32'd0);
        send_item(OP_PUSH16, 32'd64);
        send_item(OP_CALL, 32'd0);
        send_item(OP_POP, 32'd255);
        send_item(OP_POP, 32'd255);
        drain_results();
    endtask

    // Random programs: mostly well-formed sequences, some noise.
    task automatic test_random_programs(int count);
        int   sent;
        int   pick;
        logic [4:0] op;
        sent = 0;
        while (sent < count) begin
            if (sent % 300 == 299) begin
                drain_results();
                write_reg(CFG_STACK_LIMIT, ($urandom_range(0, 3) == 0) ?
                          64'($urandom_range(0, 511)) : 64'($urandom_range(200, 256)));
                write_reg(CFG_BUILTIN_COUNT, 64'($urandom_range(0, 127)));
                write_reg(CFG_BUILTIN_MASK, {$urandom, $urandom});
                write_reg(CFG_START_ADDRESS, {$urandom} & 64'hFFFF);
            end
            no_idle = (sent >= 600 && sent < 800);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                op = ($urandom_range(0, 1) ? OP_SADD : OP_UADD) + 5'($urandom_range(0, 4));
                if ($urandom_range(0, 9) < 8) begin
                    arith_pair(op, 8'($urandom),
                               ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
                    sent += 3;
                end else begin
                    send_item(op, $urandom);
                    sent += 1;
                end
            end else if (pick < 65) begin
                send_item(OP_PUSH8 + 5'($urandom_range(0, 2)), $urandom);
                sent += 1;
            end else if (pick < 78) begin
                send_item(OP_POP, ($urandom & 32'hFFFF_FF00) |
                          (($urandom_range(0, 9) == 0) ? 8'($urandom) :
                           8'($urandom_range(0, stk_head > 8 ? 8 : stk_head))));
                sent += 1;
            end else if (pick < 92) begin
                send_item(OP_PUSH16, ($urandom & 32'hFFFF_0000) |
                          (($urandom_range(0, 5) == 0) ? ($urandom & 16'hFFFF) :
                           $urandom_range(0, 70)));
                send_item(OP_CALL, $urandom);
                sent += 2;
            end else if (pick < 96) begin
                send_item(OP_END, $urandom);
                sent += 1;
            end else begin
                send_item(5'($urandom_range(16, 31)), $urandom);
                sent += 1;
            end
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Output stall: random, except during the no-idle stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 31);
    end

    // Compare each returned item with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item %p", o_out_item);
                failed = 1'b1;
            end else begin
                exp_item = pending_results.pop_front();
                if (o_out_item.status !== exp_item.status) begin
                    $error("status exp %0d got %0d", exp_item.status, o_out_item.status);
                    failed = 1'b1;
                end
                if (o_out_item.builtin_request !== exp_item.builtin_request) begin
                    $error("builtin_request exp %0d got %0d",
                           exp_item.builtin_request, o_out_item.builtin_request);
                    failed = 1'b1;
                end
                if (o_out_item.builtin_id !== exp_item.builtin_id) begin
                    $error("builtin_id exp %h got %h", exp_item.builtin_id, o_out_item.builtin_id);
                    failed = 1'b1;
                end
                if (o_out_item.arith_value !== exp_item.arith_value) begin
                    $error("arith_value exp %h got %h",
                           exp_item.arith_value, o_out_item.arith_value);
                    failed = 1'b1;
                end
                if (o_out_item.next_address !== exp_item.next_address) begin
                    $error("next_address exp %h got %h",
                           exp_item.next_address, o_out_item.next_address);
                    failed = 1'b1;
                end
                if (o_out_item.stack_depth !== exp_item.stack_depth) begin
                    $error("stack_depth exp %0d got %0d",
                           exp_item.stack_depth, o_out_item.stack_depth);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles in which no item is accepted or returned and no register write is accepted.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 5000) begin
            $display("byte_stack_machine_step_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stk_head = 0;
        instr_addr = 0;
        stack_limit_reg = 256;
        builtin_count_reg = 0;
        builtin_mask_reg = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_programs(1410);
        repeat (30) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("byte_stack_machine_step_tb OK");
        end else begin
            $display("byte_stack_machine_step_tb NOT OK");
        end
        $finish;
    end

endmodule
